FILE: hw/rtl/grapheme_cluster_segmenter_unit_macros.svh
// Assertion helpers shared by the segmenter RTL.
`ifndef GRAPHEME_CLUSTER_SEGMENTER_UNIT_MACROS_SVH
`define GRAPHEME_CLUSTER_SEGMENTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GCS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segmenter property violated");

// Next-cycle implication, disabled during reset.
`define GCS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segmenter property violated");

`endif

FILE: hw/rtl/gcs_pkg.sv
`timescale 1ns / 1ps
package gcs_pkg;

  typedef enum logic [3:0] {
    G_OTHER   = 4'd0,
    G_CR      = 4'd1,
    G_LF      = 4'd2,
    G_CONTROL = 4'd3,
    G_EXTEND  = 4'd4,
    G_SPACING = 4'd5,
    G_PREPEND = 4'd6,
    G_L       = 4'd7,
    G_V       = 4'd8,
    G_T       = 4'd9,
    G_LV      = 4'd10,
    G_LVT     = 4'd11
  } gcs_gclass_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CR     = 2'd1,
    MODE_CLOSED = 2'd2,
    MODE_OPEN   = 2'd3
  } gcs_mode_t;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_COMPLEX_CONTEXT = 2'd0;
  localparam logic [1:0] REG_COMBINING_MARK  = 2'd1;
  localparam logic [1:0] REG_ALPHABETIC      = 2'd2;
  localparam logic [1:0] REG_SPACE           = 2'd3;

  localparam int LB_W = 6;
  localparam logic [1:0] WIDE_COLUMNS = 2'd2;

  // East asian width codes
  localparam logic [2:0] EAW_Z = 3'd0;
  localparam logic [2:0] EAW_W = 3'd5;
  localparam logic [2:0] EAW_F = 3'd6;

  typedef struct packed {
    logic [LB_W-1:0] complex_context;
    logic [LB_W-1:0] combining_mark;
    logic [LB_W-1:0] alphabetic;
    logic [LB_W-1:0] space;
  } gcs_codes_t;

  typedef struct packed {
    logic full;
    logic empty;
  } gcs_q_stat_t;

  function automatic logic [1:0] columns_of(input logic [2:0] w);
    if (w == EAW_W || w == EAW_F) return WIDE_COLUMNS;
    if (w == EAW_Z) return 2'd0;
    return 2'd1;
  endfunction

  function automatic logic hangul_joins(input gcs_gclass_t p, input gcs_gclass_t n);
    logic j;
    j = 1'b0;
    if (p == G_L)
      j = (n == G_L) || (n == G_V) || (n == G_LV) || (n == G_LVT);
    else if (p == G_LV || p == G_V)
      j = (n == G_V) || (n == G_T);
    else if (p == G_LVT || p == G_T)
      j = (n == G_T);
    return j;
  endfunction

endpackage

FILE: hw/rtl/gcs_front.sv
`timescale 1ns / 1ps
module gcs_front import gcs_pkg::*; #(
  parameter int POSITION_WIDTH = 16,
  parameter int COUNT_WIDTH    = 8,
  localparam int RES_W   = POSITION_WIDTH + 2 * COUNT_WIDTH + 2 * LB_W + 2,
  localparam int ENTRY_W = 1 + 2 * RES_W
) (
  input  logic                clk,
  input  logic                rst,
  input  gcs_codes_t          codes,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [3:0]          grapheme_class,
  input  logic [LB_W-1:0]     break_class,
  input  logic [2:0]          width_class,
  input  logic                last_char,
  input  gcs_q_stat_t         q_stat,
  output logic                push,
  output logic [ENTRY_W-1:0]  entry
);

  localparam int PW = POSITION_WIDTH;
  localparam int CW = COUNT_WIDTH;

  gcs_mode_t          open_mode, open_mode_next;
  logic [PW-1:0]      char_position;
  logic [PW-1:0]      open_start, open_start_next;
  logic [CW-1:0]      open_length, open_length_next;
  logic [1:0]         base_columns, base_columns_next;
  logic [CW-1:0]      prepend_columns, prepend_columns_next;
  logic [CW-1:0]      extend_columns, extend_columns_next;
  gcs_gclass_t        previous_grapheme, previous_grapheme_next;
  logic [LB_W-1:0]    open_base_lb, open_base_lb_next;
  logic [LB_W-1:0]    open_ext_lb, open_ext_lb_next;
  logic               open_ext_known, open_ext_known_next;

  gcs_gclass_t        g;
  logic [1:0]         col;
  logic               is_ext, cr_lf, open_ok, hj;
  logic               j_hangul, j_ext, j_prep, joined, emit_old, accept;
  logic [CW-1:0]      cols_cur, cols_new;
  logic [RES_W-1:0]   res_old, res_new;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] widen2(input logic [1:0] v);
    return {{(CW-2){1'b0}}, v};
  endfunction

  function automatic logic [RES_W-1:0] pack_res(
    input logic [PW-1:0]   start,
    input logic [CW-1:0]   len,
    input logic [CW-1:0]   cols,
    input logic [LB_W-1:0] base_lb,
    input logic            known,
    input logic [LB_W-1:0] ext_lb,
    input logic            eos
  );
    return {start, len, cols, base_lb, known, known ? ext_lb : {LB_W{1'b0}}, eos};
  endfunction

  assign item_stall = q_stat.full;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    g       = (grapheme_class > G_LVT) ? G_OTHER : gcs_gclass_t'(grapheme_class);
    col     = columns_of(width_class);
    is_ext  = (g == G_EXTEND) || (g == G_SPACING);
    cr_lf   = (open_mode == MODE_CR) && (g == G_LF);
    open_ok = (open_mode == MODE_OPEN) && (g != G_CONTROL) && (g != G_CR) && (g != G_LF);
    hj      = hangul_joins(previous_grapheme, g);

    j_hangul = open_ok && hj;
    j_ext    = open_ok && !hj && is_ext;
    j_prep   = open_ok && !hj && !is_ext && (previous_grapheme == G_PREPEND);
    joined   = cr_lf || j_hangul || j_ext || j_prep;
    emit_old = !joined && (open_mode != MODE_NONE);

    open_mode_next         = open_mode;
    open_start_next        = open_start;
    open_length_next       = joined ? sat_add(open_length, {{(CW-1){1'b0}}, 1'b1}) : open_length;
    base_columns_next      = base_columns;
    prepend_columns_next   = prepend_columns;
    extend_columns_next    = extend_columns;
    previous_grapheme_next = previous_grapheme;
    open_base_lb_next      = open_base_lb;
    open_ext_lb_next       = open_ext_lb;
    open_ext_known_next    = open_ext_known;

    if (cr_lf) begin
      extend_columns_next = sat_add(extend_columns, widen2(col));
      open_mode_next      = MODE_CLOSED;
    end else if (j_hangul) begin
      base_columns_next      = WIDE_COLUMNS;
      previous_grapheme_next = g;
    end else if (j_ext) begin
      extend_columns_next = sat_add(extend_columns, widen2(col));
      if (break_class != codes.combining_mark && break_class != codes.complex_context) begin
        open_ext_lb_next    = break_class;
        open_ext_known_next = 1'b1;
      end
    end else if (j_prep) begin
      open_ext_lb_next = (break_class != codes.complex_context) ? break_class
                                                                 : codes.alphabetic;
      open_ext_known_next    = 1'b1;
      prepend_columns_next   = sat_add(prepend_columns, widen2(base_columns));
      base_columns_next      = col;
      previous_grapheme_next = g;
    end else begin
      open_start_next        = char_position;
      open_length_next       = {{(CW-1){1'b0}}, 1'b1};
      base_columns_next      = col;
      prepend_columns_next   = '0;
      extend_columns_next    = '0;
      previous_grapheme_next = g;
      if (break_class != codes.complex_context)
        open_base_lb_next = break_class;
      else if (is_ext)
        open_base_lb_next = codes.combining_mark;
      else
        open_base_lb_next = codes.alphabetic;
      open_ext_lb_next    = '0;
      open_ext_known_next = 1'b0;
      if (g == G_CR)
        open_mode_next = MODE_CR;
      else if (g == G_LF || g == G_CONTROL || break_class == codes.space)
        open_mode_next = MODE_CLOSED;
      else
        open_mode_next = MODE_OPEN;
    end

    cols_cur = sat_add(sat_add(widen2(base_columns), prepend_columns), extend_columns);
    cols_new = sat_add(sat_add(widen2(base_columns_next), prepend_columns_next),
                       extend_columns_next);
    res_old  = pack_res(open_start, open_length, cols_cur, open_base_lb,
                        open_ext_known, open_ext_lb, 1'b0);
    res_new  = pack_res(open_start_next, open_length_next, cols_new, open_base_lb_next,
                        open_ext_known_next, open_ext_lb_next, 1'b1);

    push  = accept && (emit_old || last_char);
    entry = emit_old ? {last_char, res_old, res_new} : {1'b0, res_new, res_new};
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      open_mode         <= MODE_NONE;
      char_position     <= '0;
      open_start        <= '0;
      open_length       <= '0;
      base_columns      <= '0;
      prepend_columns   <= '0;
      extend_columns    <= '0;
      previous_grapheme <= G_OTHER;
      open_base_lb      <= '0;
      open_ext_lb       <= '0;
      open_ext_known    <= 1'b0;
    end else if (accept) begin
      open_mode         <= open_mode_next;
      char_position     <= char_position + 1'b1;
      open_start        <= open_start_next;
      open_length       <= open_length_next;
      base_columns      <= base_columns_next;
      prepend_columns   <= prepend_columns_next;
      extend_columns    <= extend_columns_next;
      previous_grapheme <= previous_grapheme_next;
      open_base_lb      <= open_base_lb_next;
      open_ext_lb       <= open_ext_lb_next;
      open_ext_known    <= open_ext_known_next;
    end
  end

endmodule

FILE: hw/rtl/gcs_fifo.sv
`timescale 1ns / 1ps
`include "grapheme_cluster_segmenter_unit_macros.svh"
module gcs_fifo import gcs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output gcs_q_stat_t      q_stat
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);
  assign rd_data      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `GCS_ASSERT_IMPL(a_no_push_when_full, clk, rst, push, !q_stat.full)
  `GCS_ASSERT_IMPL(a_no_pop_when_empty, clk, rst, pop, !q_stat.empty)
  `GCS_ASSERT_NEXT(a_count_grows, clk, rst, push && !pop, count == CNT_W'($past(count) + 1'b1))

endmodule

FILE: hw/rtl/gcs_back.sv
`timescale 1ns / 1ps
`include "grapheme_cluster_segmenter_unit_macros.svh"
module gcs_back import gcs_pkg::*; #(
  parameter int POSITION_WIDTH = 16,
  parameter int COUNT_WIDTH    = 8,
  localparam int RES_W   = POSITION_WIDTH + 2 * COUNT_WIDTH + 2 * LB_W + 2,
  localparam int ENTRY_W = 1 + 2 * RES_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  gcs_q_stat_t               q_stat,
  input  logic [ENTRY_W-1:0]        entry,
  output logic                      pop,
  output logic                      cluster_valid,
  input  logic                      cluster_stall,
  output logic [POSITION_WIDTH-1:0] cluster_start,
  output logic [COUNT_WIDTH-1:0]    cluster_length,
  output logic [COUNT_WIDTH-1:0]    cluster_columns,
  output logic [LB_W-1:0]           base_lb_class,
  output logic                      extender_lb_known,
  output logic [LB_W-1:0]           extender_lb_class,
  output logic                      end_of_string
);

  logic             cur_valid, cur_sel, cur_b_valid;
  logic [RES_W-1:0] cur_a, cur_b, shown;
  logic             fire, take;

  assign cluster_valid = cur_valid;
  assign fire  = cur_valid && !cluster_stall;
  // Move to the next entry once its last half is gone, or when none is held
  assign take  = !cur_valid || (fire && (cur_sel || !cur_b_valid));
  assign pop   = take && !q_stat.empty;
  assign shown = cur_sel ? cur_b : cur_a;

  assign {cluster_start, cluster_length, cluster_columns, base_lb_class,
          extender_lb_known, extender_lb_class, end_of_string} = shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_sel   <= 1'b0;
    end else if (take) begin
      cur_valid <= !q_stat.empty;
      cur_sel   <= 1'b0;
    end else if (fire) begin
      cur_sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) {cur_b_valid, cur_a, cur_b} <= entry;
  end

  `GCS_ASSERT_IMPL(a_sel_needs_pair, clk, rst, cur_sel, cur_valid && cur_b_valid)
  `GCS_ASSERT_IMPL(a_no_pop_on_stall, clk, rst, cluster_valid && cluster_stall, !pop)
  `GCS_ASSERT_NEXT(a_pair_done, clk, rst, fire && cur_sel, !cur_sel)

endmodule

FILE: hw/rtl/grapheme_cluster_segmenter_unit.sv
`timescale 1ns / 1ps
// Grapheme cluster segmenter: takes one character per transaction (grapheme,
// line-break and east-asian-width classes plus a last-character mark) and
// returns one transaction per finished cluster with its start index, length,
// display columns, resolved base line-break class and extender class. The
// front end accepts a character every cycle and advances the open-cluster
// state in that same cycle; finished clusters go through a QUEUE_DEPTH-entry
// queue to the output register, which sends one cluster per cycle while
// cluster_stall is low. A character that both closes the open cluster and ends
// the string yields two clusters, sent as two transactions; with the queue
// and output register empty, the first cluster of a character is written into
// the queue and then into the output register before it is valid. Input
// stalls only while the queue is full. The code registers (SA, CM, AL, SP
// class codes) sit at byte addresses 0, 4, 8 and 12 and may be written only
// while the block is idle.
module grapheme_cluster_segmenter_unit import gcs_pkg::*; #(
  parameter int POSITION_WIDTH = 16,
  parameter int COUNT_WIDTH    = 8,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // character transactions
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [3:0]                grapheme_class,
  input  logic [LB_W-1:0]           break_class,
  input  logic [2:0]                width_class,
  input  logic                      last_char,
  // cluster transactions
  output logic                      cluster_valid,
  input  logic                      cluster_stall,
  output logic [POSITION_WIDTH-1:0] cluster_start,
  output logic [COUNT_WIDTH-1:0]    cluster_length,
  output logic [COUNT_WIDTH-1:0]    cluster_columns,
  output logic [LB_W-1:0]           base_lb_class,
  output logic                      extender_lb_known,
  output logic [LB_W-1:0]           extender_lb_class,
  output logic                      end_of_string
);

  localparam int RES_W   = POSITION_WIDTH + 2 * COUNT_WIDTH + 2 * LB_W + 2;
  localparam int ENTRY_W = 1 + 2 * RES_W;

  gcs_codes_t         codes;
  gcs_q_stat_t        q_stat;
  logic               push, pop, cfg_write;
  logic [ENTRY_W-1:0] wr_entry, rd_entry;
  logic [1:0]         reg_index;
  logic [LB_W-1:0]    read_value;

  // Register file: never inserts wait states, write on the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.complex_context <= LB_W'(1);
      codes.combining_mark  <= LB_W'(2);
      codes.alphabetic      <= LB_W'(3);
      codes.space           <= LB_W'(4);
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_COMPLEX_CONTEXT: codes.complex_context <= pwdata[LB_W-1:0];
        REG_COMBINING_MARK:  codes.combining_mark  <= pwdata[LB_W-1:0];
        REG_ALPHABETIC:      codes.alphabetic      <= pwdata[LB_W-1:0];
        REG_SPACE:           codes.space           <= pwdata[LB_W-1:0];
        default:             codes.space           <= codes.space;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_COMPLEX_CONTEXT: read_value = codes.complex_context;
      REG_COMBINING_MARK:  read_value = codes.combining_mark;
      REG_ALPHABETIC:      read_value = codes.alphabetic;
      REG_SPACE:           read_value = codes.space;
      default:             read_value = '0;
    endcase
    prdata = {{(32-LB_W){1'b0}}, read_value};
  end

  // Front end: join decisions and open-cluster state, one character a cycle while the queue is not full
  gcs_front #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .codes         (codes),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .grapheme_class(grapheme_class),
    .break_class   (break_class),
    .width_class   (width_class),
    .last_char     (last_char),
    .q_stat        (q_stat),
    .push          (push),
    .entry         (wr_entry)
  );

  // Queue of finished clusters, one or two per entry
  gcs_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(wr_entry),
    .pop    (pop),
    .rd_data(rd_entry),
    .q_stat (q_stat)
  );

  // Back end: output register, splits a two-cluster entry over two transactions
  gcs_back #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_stat           (q_stat),
    .entry            (rd_entry),
    .pop              (pop),
    .cluster_valid    (cluster_valid),
    .cluster_stall    (cluster_stall),
    .cluster_start    (cluster_start),
    .cluster_length   (cluster_length),
    .cluster_columns  (cluster_columns),
    .base_lb_class    (base_lb_class),
    .extender_lb_known(extender_lb_known),
    .extender_lb_class(extender_lb_class),
    .end_of_string    (end_of_string)
  );

endmodule
